@@ src/card_slot_poll_sequencer_macros.svh @@
// Assertion macros for the card slot poll sequencer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CARD_SLOT_POLL_SEQUENCER_MACROS_SVH
`define CARD_SLOT_POLL_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CSPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CSPS_ASSERT_NOW(lbl, ante, cons, msg)

`define CSPS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ src/csps_pkg.sv @@
`timescale 1ns / 1ps

package csps_pkg;

	localparam int CntWidth = 16;

	// Pending event flag positions
	localparam int EvReqOk    = 0;
	localparam int EvReqFail  = 1;
	localparam int EvReqNew   = 2;
	localparam int EvInitOk   = 3;
	localparam int EvInitFail = 4;
	localparam int EvInitTmo  = 5;
	localparam int EvCount    = 6;

	localparam logic [EvCount-1:0] EvReqGroup  = 6'b000111;
	localparam logic [EvCount-1:0] EvInitGroup = 6'b111000;

	typedef enum logic [2:0] {
		CMD_NONE = 3'd0,
		CMD_INFO = 3'd1,
		CMD_INIT = 3'd2,
		CMD_LOAD = 3'd3,
		CMD_READ = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_EMPTY = 3'd0,
		ST_INFO  = 3'd1,
		ST_INIT  = 3'd2,
		ST_LOAD  = 3'd3,
		ST_READY = 3'd4
	} slot_st_t;

	// Presence mask bits
	localparam int PresRead = 0;
	localparam int PresNew  = 2;

	typedef struct packed {
		logic port;
		logic req_ok_in;
		logic req_fail_in;
		logic req_newcard_in;
		logic init_ok_in;
		logic init_fail_in;
		logic init_timeout_in;
		logic dialog_open;
		logic paused;
	} poll_item_t;

	typedef struct packed {
		cmd_t       command;
		logic       command_port;
		slot_st_t   port_state;
		logic [2:0] present_mask;
		logic       turn;
	} result_item_t;

endpackage

@@ src/csps_ifs.sv @@
`timescale 1ns / 1ps

interface csps_poll_if;
	import csps_pkg::*;

	logic       valid;
	logic       ready;
	poll_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface csps_result_if;
	import csps_pkg::*;

	logic         valid;
	logic         ready;
	result_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/card_slot_poll_sequencer.sv @@
`timescale 1ns / 1ps

// Card slot poll sequencer: takes one poll step per transaction on the poll channel and
// returns exactly one result transaction for it, carrying the command to issue (none, info,
// init, load or read), the port it addresses, the served port's new state and presence mask,
// and the port whose turn comes next. A step is captured in an input register, evaluated
// against the per-port state, the shared pending event flags, the turn bit and the poll
// countdown, and its result lands in the result register: the input register and the result
// register lie between a poll transaction and its result transaction, and a stalled result
// side can hold the step in the input register. A new step is taken every clock while the
// result side does not stall, because the read-modify-write of the shared event flags and
// port state that the following step must see completes as the step moves into the result
// register. The input side accepts a step whenever the input register is empty or can drain
// into a free or emptying result register.

`include "card_slot_poll_sequencer_macros.svh"

module card_slot_poll_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	csps_poll_if.sink            poll,
	csps_result_if.source        result
);
	import csps_pkg::*;

	// Input stage
	logic       valid_s1;
	poll_item_t item_s1;

	// Result register
	logic         out_valid_q;
	result_item_t out_data_q;

	// Block state
	slot_st_t                slot_q [2];
	logic [2:0]              pres_q [2];
	logic [EvCount-1:0]      pending_q;
	logic                    turn_q;
	logic signed [CntWidth-1:0] cnt_q;

	logic advance;

	// Next-state values for the step held in the input register
	logic [EvCount-1:0]      ev;
	logic [EvCount-1:0]      ev_n;
	slot_st_t                st;
	slot_st_t                st_n;
	logic [2:0]              pres;
	logic [2:0]              pres_n;
	cmd_t                    cmd;
	logic                    hand;
	logic                    try_poll;
	logic                    poll_go;
	logic                    cnt_pos;
	logic signed [CntWidth-1:0] cnt_n;
	logic                    turn_n;

	// Move the held step into the result register when that register is free or draining
	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign poll.ready  = !valid_s1 || advance;

	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	always_comb begin
		// Latch the arrivals of this step into the pending flags first
		ev = pending_q | {item_s1.init_timeout_in, item_s1.init_fail_in,
			item_s1.init_ok_in, item_s1.req_newcard_in, item_s1.req_fail_in,
			item_s1.req_ok_in};
		st       = slot_q[item_s1.port];
		pres     = pres_q[item_s1.port];
		ev_n     = ev;
		st_n     = st;
		pres_n   = pres;
		cmd      = CMD_NONE;
		hand     = 1'b0;
		try_poll = 1'b0;

		case (st)
			ST_EMPTY: begin
				pres_n   = 3'b000;
				try_poll = 1'b1;
			end
			ST_INFO: begin
				if (ev[EvReqOk]) begin
					ev_n[EvReqOk] = 1'b0;
					if (!pres[PresRead]) begin
						// No card read yet: bring the slot up
						ev_n = ev_n & ~EvInitGroup;
						cmd  = CMD_INIT;
						st_n = ST_INIT;
					end else begin
						st_n = ST_READY;
						hand = 1'b1;
					end
				end else if (ev[EvReqFail]) begin
					ev_n[EvReqFail] = 1'b0;
					st_n            = ST_EMPTY;
					pres_n[PresNew] = 1'b0;
					hand            = 1'b1;
				end else if (ev[EvReqNew]) begin
					ev_n           = ev & ~EvInitGroup;
					ev_n[EvReqNew] = 1'b0;
					cmd            = CMD_INIT;
					st_n           = ST_INIT;
				end
			end
			ST_INIT: begin
				if (ev[EvInitOk]) begin
					ev_n = ev & ~EvReqGroup & ~(EvCount'(1) << EvInitOk);
					cmd  = CMD_LOAD;
					st_n = ST_LOAD;
				end else if (ev[EvInitFail] || ev[EvInitTmo]) begin
					ev_n[EvInitFail] = 1'b0;
					ev_n[EvInitTmo]  = 1'b0;
					st_n             = ST_EMPTY;
					hand             = 1'b1;
				end
			end
			ST_LOAD: begin
				if (ev[EvReqOk]) begin
					ev_n[EvReqOk] = 1'b0;
					st_n          = ST_READY;
					hand          = 1'b1;
					// Skip the automatic read while a dialog is up
					if (!item_s1.dialog_open) begin
						pres_n[PresRead] = 1'b1;
						cmd              = CMD_READ;
					end
				end else if (ev[EvReqFail]) begin
					ev_n[EvReqFail] = 1'b0;
					st_n            = ST_EMPTY;
					hand            = 1'b1;
				end else if (ev[EvReqNew]) begin
					ev_n[EvReqNew]  = 1'b0;
					st_n            = ST_READY;
					pres_n[PresNew] = 1'b1;
					hand            = 1'b1;
				end
			end
			ST_READY: begin
				pres_n[PresRead] = 1'b1;
				try_poll         = 1'b1;
			end
			default: begin
			end
		endcase

		// Poll attempt: only on our turn while not paused, and only once the countdown has run out
		poll_go = try_poll && !item_s1.paused && (item_s1.port == turn_q);
		cnt_pos = !cnt_q[CntWidth-1] && (cnt_q != '0);
		cnt_n   = cnt_q;
		if (hand) begin
			cnt_n = '0;
		end else if (poll_go) begin
			// Hold at the most negative value rather than wrap
			if (cnt_q != {1'b1, {(CntWidth-1){1'b0}}}) begin
				cnt_n = cnt_q - CntWidth'(1);
			end
		end
		if (poll_go && !cnt_pos) begin
			ev_n = ev_n & ~EvReqGroup;
			cmd  = CMD_INFO;
			st_n = ST_INFO;
		end

		turn_n = hand ? !turn_q : turn_q;
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			slot_q[0]   <= ST_EMPTY;
			slot_q[1]   <= ST_EMPTY;
			pres_q[0]   <= 3'b000;
			pres_q[1]   <= 3'b000;
			pending_q   <= '0;
			turn_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (poll.ready) begin
				valid_s1 <= poll.valid;
			end
			if (advance) begin
				out_valid_q            <= 1'b1;
				slot_q[item_s1.port]   <= st_n;
				pres_q[item_s1.port]   <= pres_n;
				pending_q              <= ev_n;
				turn_q                 <= turn_n;
				cnt_q                  <= cnt_n;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			item_s1 <= poll.data;
		end
		if (advance) begin
			out_data_q.command      <= cmd;
			out_data_q.command_port <= (cmd != CMD_NONE) ? item_s1.port : 1'b0;
			out_data_q.port_state   <= st_n;
			out_data_q.present_mask <= pres_n;
			out_data_q.turn         <= turn_n;
		end
	end

	// The countdown only ever counts down from zero, so it is never positive
	`CSPS_ASSERT_NOW(a_cnt_not_pos, 1'b1, cnt_q[CntWidth-1] || (cnt_q == '0), "countdown positive")

	// An info request goes only to the port whose turn it is, with the turn kept
	`CSPS_ASSERT_NOW(a_info_on_turn, out_valid_q && (out_data_q.command == CMD_INFO), out_data_q.command_port == out_data_q.turn, "info request off turn")

	// A read is issued only as the port becomes ready with its card marked read
	`CSPS_ASSERT_NOW(a_read_marks, out_valid_q && (out_data_q.command == CMD_READ), (out_data_q.port_state == ST_READY) && out_data_q.present_mask[PresRead], "read without ready card")

	// A finished step always leaves a result behind
	`CSPS_ASSERT_NEXT(a_adv_result, advance, out_valid_q, "result lost")

endmodule

@@ tb/card_slot_poll_sequencer_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the two-port card slot poll sequencer. Poll steps go in
// through the poll channel and each one yields exactly one result transaction. A
// behavioural copy of the sequencer predicts that result at the moment the step is
// accepted. The prediction waits in a queue until the matching result comes out.
module card_slot_poll_sequencer_tb;
	import csps_pkg::*;

	// One-hot masks for the six pending event flags
	localparam logic [EvCount-1:0] NoEv       = '0;
	localparam logic [EvCount-1:0] ReqOkEv    = 6'b1 << EvReqOk;
	localparam logic [EvCount-1:0] ReqFailEv  = 6'b1 << EvReqFail;
	localparam logic [EvCount-1:0] ReqNewEv   = 6'b1 << EvReqNew;
	localparam logic [EvCount-1:0] InitOkEv   = 6'b1 << EvInitOk;
	localparam logic [EvCount-1:0] InitFailEv = 6'b1 << EvInitFail;
	localparam logic [EvCount-1:0] InitTmoEv  = 6'b1 << EvInitTmo;

	localparam logic signed [CntWidth-1:0] CountFloor = 16'sh8000;
	localparam int LongHold   = 200;
	localparam int TailCycles = 8;

	logic clk = 1'b0;
	logic arst_n;

	csps_poll_if   poll ();
	csps_result_if result ();

	card_slot_poll_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll),
		.result (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the sequencer state, advanced once per accepted poll step
	slot_st_t                    slot_st [2];
	logic [2:0]                  slot_mask [2];
	logic [EvCount-1:0]          pend_ev;
	logic                        turn_q;
	logic signed [CntWidth-1:0]  countdown;

	result_item_t result_expect_q [$];
	result_item_t due;

	int  fail_count;
	int  steps_sent;
	int  results_seen;
	int  cmd_tally [5];
	bit  idle_enable;
	bit  long_hold_req;
	int  sink_gap;

	function automatic void hand_turn_over();
		turn_q    = ~turn_q;
		countdown = '0;
	endfunction

	// Advance the shadow state by one poll step and return the result it must produce
	function automatic result_item_t predict_step(input poll_item_t s);
		result_item_t               r;
		logic                       p;
		logic                       try_poll;
		cmd_t                       cmd;
		logic signed [CntWidth-1:0] was;
		p        = s.port;
		cmd      = CMD_NONE;
		try_poll = 1'b0;
		// Latch the arrivals before acting on them
		pend_ev |= {s.init_timeout_in, s.init_fail_in, s.init_ok_in,
			s.req_newcard_in, s.req_fail_in, s.req_ok_in};
		case (slot_st[p])
			ST_EMPTY: begin
				slot_mask[p] = '0;
				try_poll     = 1'b1;
			end
			ST_INFO: begin
				if (pend_ev[EvReqOk]) begin
					pend_ev[EvReqOk] = 1'b0;
					if (!slot_mask[p][PresRead]) begin
						pend_ev    &= ~EvInitGroup;
						cmd         = CMD_INIT;
						slot_st[p]  = ST_INIT;
					end else begin
						slot_st[p] = ST_READY;
						hand_turn_over();
					end
				end else if (pend_ev[EvReqFail]) begin
					pend_ev[EvReqFail]    = 1'b0;
					slot_st[p]            = ST_EMPTY;
					slot_mask[p][PresNew] = 1'b0;
					hand_turn_over();
				end else if (pend_ev[EvReqNew]) begin
					pend_ev[EvReqNew]  = 1'b0;
					pend_ev           &= ~EvInitGroup;
					cmd                = CMD_INIT;
					slot_st[p]         = ST_INIT;
				end
			end
			ST_INIT: begin
				if (pend_ev[EvInitOk]) begin
					pend_ev[EvInitOk]  = 1'b0;
					pend_ev           &= ~EvReqGroup;
					cmd                = CMD_LOAD;
					slot_st[p]         = ST_LOAD;
				end else if (pend_ev[EvInitFail] || pend_ev[EvInitTmo]) begin
					pend_ev[EvInitFail] = 1'b0;
					pend_ev[EvInitTmo]  = 1'b0;
					slot_st[p]          = ST_EMPTY;
					hand_turn_over();
				end
			end
			ST_LOAD: begin
				if (pend_ev[EvReqOk]) begin
					pend_ev[EvReqOk] = 1'b0;
					slot_st[p]       = ST_READY;
					if (!s.dialog_open) begin
						slot_mask[p][PresRead] = 1'b1;
						cmd                    = CMD_READ;
					end
					hand_turn_over();
				end else if (pend_ev[EvReqFail]) begin
					pend_ev[EvReqFail] = 1'b0;
					slot_st[p]         = ST_EMPTY;
					hand_turn_over();
				end else if (pend_ev[EvReqNew]) begin
					pend_ev[EvReqNew]     = 1'b0;
					slot_st[p]            = ST_READY;
					slot_mask[p][PresNew] = 1'b1;
					hand_turn_over();
				end
			end
			ST_READY: begin
				slot_mask[p][PresRead] = 1'b1;
				try_poll               = 1'b1;
			end
			default: ;
		endcase
		// Only the port holding the turn may start a new info request
		if (try_poll && !s.paused && p == turn_q) begin
			was = countdown;
			if (countdown != CountFloor)
				countdown = countdown - 1'b1;
			if (was <= 0) begin
				pend_ev    &= ~EvReqGroup;
				cmd         = CMD_INFO;
				slot_st[p]  = ST_INFO;
			end
		end
		r.command      = cmd;
		r.command_port = (cmd != CMD_NONE) ? p : 1'b0;
		r.port_state   = slot_st[p];
		r.present_mask = slot_mask[p];
		r.turn         = turn_q;
		cmd_tally[cmd]++;
		return r;
	endfunction

	function automatic poll_item_t mk_step(input logic port, input logic [EvCount-1:0] ev,
			input logic dialog, input logic hold);
		poll_item_t s;
		s.port            = port;
		s.req_ok_in       = ev[EvReqOk];
		s.req_fail_in     = ev[EvReqFail];
		s.req_newcard_in  = ev[EvReqNew];
		s.init_ok_in      = ev[EvInitOk];
		s.init_fail_in    = ev[EvInitFail];
		s.init_timeout_in = ev[EvInitTmo];
		s.dialog_open     = dialog;
		s.paused          = hold;
		return s;
	endfunction

	// Mostly steer events towards the port mid-exchange so that exchanges run to the end;
	// one step in five is pure noise over all nine bits.
	function automatic poll_item_t random_step();
		logic [8:0]         raw;
		logic [EvCount-1:0] ev;
		logic               port;
		int                 live;
		int                 pick;
		if ($urandom_range(0, 4) == 0) begin
			raw = 9'($urandom);
			return poll_item_t'(raw);
		end
		live = -1;
		foreach (slot_st[i])
			if (slot_st[i] inside {ST_INFO, ST_INIT, ST_LOAD})
				live = i;
		ev = NoEv;
		if (live >= 0) begin
			port = ($urandom_range(0, 4) != 0) ? live[0] : ~live[0];
			if ($urandom_range(0, 9) < 6) begin
				pick = $urandom_range(0, 4);
				if (slot_st[live[0]] == ST_INIT)
					ev = (pick < 3) ? InitOkEv : (pick == 3) ? InitFailEv : InitTmoEv;
				else
					ev = (pick < 3) ? ReqOkEv : (pick == 3) ? ReqFailEv : ReqNewEv;
			end
		end else begin
			port = ($urandom_range(0, 6) != 0) ? turn_q : ~turn_q;
		end
		if ($urandom_range(0, 9) == 0)
			ev |= 6'b1 << $urandom_range(0, EvCount - 1);
		return mk_step(port, ev, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
	endfunction

	// Offer one poll step, hold it until the sequencer takes it, then log its prediction.
	// Valid is left high so that back-to-back steps need no second assignment.
	task automatic send_step(input poll_item_t s);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			poll.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		poll.valid <= 1'b1;
		poll.data  <= s;
		do
			@(posedge clk);
		while (!poll.ready);
		result_expect_q.push_back(predict_step(s));
		steps_sent++;
	endtask

	// Drop valid and wait for every outstanding result to come back
	task automatic drain_results();
		poll.valid <= 1'b0;
		while (result_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Off-turn port, paused poll, then the first info request from port 0
	task automatic test_idle_poll();
		send_step(mk_step(1'b1, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, NoEv, 1'b0, 1'b1));
		send_step(mk_step(1'b0, NoEv, 1'b0, 1'b0));
	endtask

	// Fresh card on port 0: init, load, read
	task automatic test_read_path();
		send_step(mk_step(1'b0, ReqOkEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, InitOkEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, ReqOkEv, 1'b0, 1'b0));
	endtask

	// Port 1 loads with a dialog open, so the read is skipped
	task automatic test_dialog_suppress();
		send_step(mk_step(1'b1, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, ReqOkEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, InitOkEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, ReqOkEv, 1'b1, 1'b0));
	endtask

	// Card already read: a good info reply goes straight back to ready
	task automatic test_repoll_present();
		send_step(mk_step(1'b0, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, ReqOkEv, 1'b0, 1'b0));
	endtask

	// Every way out of info, init and load other than the read path
	task automatic test_error_exits();
		send_step(mk_step(1'b1, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, ReqFailEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, ReqNewEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, InitTmoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, ReqOkEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, InitFailEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, ReqNewEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, InitOkEv, 1'b0, 1'b0));
		send_step(mk_step(1'b0, ReqNewEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, NoEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, ReqNewEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, InitOkEv, 1'b0, 1'b0));
		send_step(mk_step(1'b1, ReqFailEv, 1'b0, 1'b0));
	endtask

	// Every input bit high at once
	task automatic test_all_events();
		send_step(mk_step(1'b1, '1, 1'b1, 1'b1));
	endtask

	task automatic test_random_traffic(input int count, input bit with_idle);
		idle_enable = with_idle;
		repeat (count)
			send_step(random_step());
	endtask

	// Hold the result side off for a long stretch while steps keep coming in
	task automatic test_output_backpressure();
		long_hold_req = 1'b1;
		test_random_traffic(20, 1'b0);
	endtask

	// Stop sending until the pipeline is empty, then resume
	task automatic test_sender_pause();
		test_random_traffic(10, 1'b1);
		drain_results();
		test_random_traffic(10, 1'b1);
	endtask

	// Result sink: random stalls, plus one long hold-off on request
	initial begin
		result.ready <= 1'b0;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			if (long_hold_req) begin
				sink_gap      = LongHold;
				long_hold_req = 1'b0;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				sink_gap = $urandom_range(1, 10);
			end else begin
				sink_gap = 0;
			end
			if (sink_gap != 0) begin
				result.ready <= 1'b0;
				repeat (sink_gap) @(posedge clk);
			end
			result.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Match each result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			results_seen++;
			if (result_expect_q.size() == 0) begin
				$error("result transaction with no poll step outstanding");
				fail_count++;
			end else begin
				due = result_expect_q.pop_front();
				if (result.data.command !== due.command) begin
					$error("command: expected %0d, actual %0d", due.command,
						result.data.command);
					fail_count++;
				end
				if (result.data.command_port !== due.command_port) begin
					$error("command_port: expected %0d, actual %0d", due.command_port,
						result.data.command_port);
					fail_count++;
				end
				if (result.data.port_state !== due.port_state) begin
					$error("port_state: expected %0d, actual %0d", due.port_state,
						result.data.port_state);
					fail_count++;
				end
				if (result.data.present_mask !== due.present_mask) begin
					$error("present_mask: expected %0d, actual %0d", due.present_mask,
						result.data.present_mask);
					fail_count++;
				end
				if (result.data.turn !== due.turn) begin
					$error("turn: expected %0d, actual %0d", due.turn, result.data.turn);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("FAIL card_slot_poll_sequencer");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		poll.valid    <= 1'b0;
		poll.data     <= '0;
		idle_enable    = 1'b1;
		long_hold_req  = 1'b0;
		fail_count     = 0;
		steps_sent     = 0;
		results_seen   = 0;
		foreach (cmd_tally[i])
			cmd_tally[i] = 0;
		// Shadow state matches the sequencer after reset
		foreach (slot_st[i]) begin
			slot_st[i]   = ST_EMPTY;
			slot_mask[i] = '0;
		end
		pend_ev   = '0;
		turn_q    = 1'b0;
		countdown = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_poll();
		test_read_path();
		test_dialog_suppress();
		test_repoll_present();
		test_error_exits();
		test_all_events();
		test_random_traffic(450, 1'b1);
		test_output_backpressure();
		test_random_traffic(250, 1'b0);
		test_sender_pause();
		test_random_traffic(450, 1'b1);
		test_random_traffic(300, 1'b0);

		drain_results();
		repeat (TailCycles) @(posedge clk);
		if (result_expect_q.size() != 0) begin
			$error("%0d predicted results never arrived", result_expect_q.size());
			fail_count++;
		end
		$display("Ran %0d poll steps and checked %0d results, including long output stalls.",
			steps_sent, results_seen);
		$display("Commands seen: %0d info, %0d init, %0d load, %0d read, %0d idle.",
			cmd_tally[CMD_INFO], cmd_tally[CMD_INIT], cmd_tally[CMD_LOAD],
			cmd_tally[CMD_READ], cmd_tally[CMD_NONE]);
		if (fail_count == 0)
			$display("PASS card_slot_poll_sequencer");
		else
			$display("FAIL card_slot_poll_sequencer");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/csps_pkg.sv
src/csps_ifs.sv
src/card_slot_poll_sequencer.sv
tb/card_slot_poll_sequencer_tb.sv
